FILE: sv/aar_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle rotation block.
package aar_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;

  // Queue between the front and back parts
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Axis unit depth: normalise, square root and division are fixed by the field widths
  localparam int NORM_STEPS = 5;
  localparam int NORM_TOP   = 32;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;
  localparam int LAT_AXIS   = (NORM_STEPS + 1) + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 1;
  localparam int LAT_ANG    = CORDIC_STEPS + 7;
  localparam int LAT_ALIGN  = LAT_AXIS - LAT_ANG;
  localparam int LAT_ALL    = LAT_AXIS + 4;

  typedef logic signed [33:0] q_t;

  localparam q_t Q_ONE       = 34'sd1 <<< 30;
  localparam q_t CORDIC_GAIN = 34'sd652032874;

  localparam int OUT_SHIFT = 30 - FRAC_BITS;
  localparam logic signed [34:0] RND_OUT = (35'sd1 <<< 29) >>> FRAC_BITS;
  localparam logic signed [34:0] OUT_LIM = 35'sd1 <<< FRAC_BITS;
  localparam logic signed [34:0] OUT_HI  = (OUT_LIM > 35'sd32767) ? 35'sd32767 : OUT_LIM;
  localparam logic signed [34:0] OUT_LO  = (-OUT_LIM < -35'sd32768) ? -35'sd32768 : -OUT_LIM;
  localparam logic [15:0] ID_DIAG = OUT_HI[15:0];

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic [31:0]      len2;
    logic             zero;
    logic [17:0]      ap;
    logic [6:0]       low7;
  } front_item_t;

  // Q30 product, rounded half up
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    p = p + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

  function automatic q_t clampq(input q_t v);
    if (v > Q_ONE) return Q_ONE;
    if (v < -Q_ONE) return -Q_ONE;
    return v;
  endfunction

  // Q30 to output format with rounding and saturation
  function automatic logic [15:0] to_out(input q_t v);
    logic signed [34:0] r;
    r = ($signed({v[33], v}) + RND_OUT) >>> OUT_SHIFT;
    if (r > OUT_HI) r = OUT_HI;
    if (r < OUT_LO) r = OUT_LO;
    return r[15:0];
  endfunction

  function automatic q_t atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h3243F6A8;
      5'd1:    a = 32'h1DAC6705;
      5'd2:    a = 32'h0FADBAFC;
      5'd3:    a = 32'h07F56EA6;
      5'd4:    a = 32'h03FEAB76;
      5'd5:    a = 32'h01FFD55B;
      5'd6:    a = 32'h00FFFAAA;
      5'd7:    a = 32'h007FFF55;
      5'd8:    a = 32'h003FFFEA;
      5'd9:    a = 32'h001FFFFD;
      5'd10:   a = 32'h000FFFFF;
      5'd11:   a = 32'h0007FFFF;
      5'd12:   a = 32'h0003FFFF;
      5'd13:   a = 32'h0001FFFF;
      5'd14:   a = 32'h0000FFFF;
      5'd15:   a = 32'h00007FFF;
      5'd16:   a = 32'h00003FFF;
      5'd17:   a = 32'h00001FFF;
      5'd18:   a = 32'h00000FFF;
      5'd19:   a = 32'h000007FF;
      5'd20:   a = 32'h000003FF;
      5'd21:   a = 32'h000001FF;
      5'd22:   a = 32'h000000FF;
      5'd23:   a = 32'h0000007F;
      5'd24:   a = 32'h0000003F;
      5'd25:   a = 32'h0000001F;
      5'd26:   a = 32'h0000000F;
      5'd27:   a = 32'h00000008;
      5'd28:   a = 32'h00000004;
      5'd29:   a = 32'h00000002;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return q_t'({2'b00, a});
  endfunction

endpackage

FILE: sv/aar_front.sv
// Front part: accepts requests, takes magnitudes and squared length, splits the angle.
module aar_front import aar_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [23:0] angle_deg,
  input  logic               q_full,
  output logic               push,
  output front_item_t        item
);

  logic        f_v_r, f_v_nxt;
  front_item_t item_r, item_nxt;
  logic        accept;

  assign in_ready = !f_v_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = f_v_r && !q_full;
  assign item     = item_r;

  always_comb begin
    logic signed [15:0] comp [3];
    logic signed [18:0] ap_s;
    comp[0] = axis_x;
    comp[1] = axis_y;
    comp[2] = axis_z;
    for (int l = 0; l < 3; l++) begin
      item_nxt.mag[l] = comp[l][15] ? 16'(-comp[l]) : comp[l];
      item_nxt.neg[l] = comp[l][15];
    end
    item_nxt.len2 = 32'(item_nxt.mag[0]) * 32'(item_nxt.mag[0])
                  + 32'(item_nxt.mag[1]) * 32'(item_nxt.mag[1])
                  + 32'(item_nxt.mag[2]) * 32'(item_nxt.mag[2]);
    item_nxt.zero = (item_nxt.len2 == '0);
    // offset keeps the quotient positive and a multiple of four quadrants
    ap_s = 19'(angle_deg >>> 7) + 19'sd65700;
    item_nxt.ap   = ap_s[17:0];
    item_nxt.low7 = angle_deg[6:0];
  end

  always_comb begin
    f_v_nxt = f_v_r;
    if (accept) f_v_nxt = 1'b1;
    else if (push) f_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: sv/aar_queue.sv
// Short queue between the front and back parts.
module aar_queue import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  front_item_t wr_item,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output front_item_t head
);

  front_item_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + Q_PTR_W'(1);
    if (pop) rp_nxt = (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + Q_PTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

FILE: sv/aar_axis.sv
// Axis unit: normalising shift, bit-serial square root and three long divisions, pipelined.
module aar_axis import aar_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][15:0] mag,
  input  logic [2:0]       neg,
  input  logic [31:0]      len2,
  output q_t               u [3]
);

  logic [61:0] nw_r [NORM_STEPS+1];
  logic [31:0] nm_r [NORM_STEPS+1][3];
  logic [2:0]  ng_r [NORM_STEPS+1];

  logic [63:0] sn_r [SQRT_STEPS+1];
  logic [63:0] sr_r [SQRT_STEPS+1];
  logic [31:0] sm_r [SQRT_STEPS+1][3];
  logic [2:0]  sg_r [SQRT_STEPS+1];

  logic [31:0] dr_r [DIV_STEPS+1][3];
  logic [61:0] dn_r [DIV_STEPS+1][3];
  logic [30:0] dq_r [DIV_STEPS+1][3];
  logic [31:0] ds_r [DIV_STEPS+1];
  logic [2:0]  dg_r [DIV_STEPS+1];

  q_t u_r [3];

  assign u = u_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nw_r[0] <= 62'(len2);
      ng_r[0] <= neg;
      for (int l = 0; l < 3; l++) nm_r[0][l] <= 32'(mag[l]);
      // shift by halving steps, each taken only while as many top bits as it shifts are clear
      for (int j = 0; j < NORM_STEPS; j++) begin
        ng_r[j+1] <= ng_r[j];
        if ((nw_r[j] >> (62 - (NORM_TOP >> j))) == '0) begin
          nw_r[j+1] <= nw_r[j] << (NORM_TOP >> j);
          for (int l = 0; l < 3; l++) nm_r[j+1][l] <= nm_r[j][l] << ((NORM_TOP >> j) / 2);
        end else begin
          nw_r[j+1] <= nw_r[j];
          for (int l = 0; l < 3; l++) nm_r[j+1][l] <= nm_r[j][l];
        end
      end

      sn_r[0] <= {2'b00, nw_r[NORM_STEPS]};
      sr_r[0] <= '0;
      sg_r[0] <= ng_r[NORM_STEPS];
      for (int l = 0; l < 3; l++) sm_r[0][l] <= nm_r[NORM_STEPS][l];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sg_r[k+1] <= sg_r[k];
        for (int l = 0; l < 3; l++) sm_r[k+1][l] <= sm_r[k][l];
        if (sn_r[k] >= sr_r[k] + (64'd1 << (60 - 2 * k))) begin
          sn_r[k+1] <= sn_r[k] - (sr_r[k] + (64'd1 << (60 - 2 * k)));
          sr_r[k+1] <= (sr_r[k] >> 1) + (64'd1 << (60 - 2 * k));
        end else begin
          sn_r[k+1] <= sn_r[k];
          sr_r[k+1] <= sr_r[k] >> 1;
        end
      end

      // numerator carries half the divisor for rounding
      ds_r[0] <= sr_r[SQRT_STEPS][31:0];
      dg_r[0] <= sg_r[SQRT_STEPS];
      for (int l = 0; l < 3; l++) begin
        dn_r[0][l] <= {sm_r[SQRT_STEPS][l], 30'd0} + 62'(sr_r[SQRT_STEPS] >> 1);
        dr_r[0][l] <= 32'(({sm_r[SQRT_STEPS][l], 30'd0} + 62'(sr_r[SQRT_STEPS] >> 1)) >> 31);
        dq_r[0][l] <= '0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        ds_r[k+1] <= ds_r[k];
        dg_r[k+1] <= dg_r[k];
        for (int l = 0; l < 3; l++) begin
          dn_r[k+1][l] <= dn_r[k][l];
          if ({dr_r[k][l][30:0], dn_r[k][l][30-k]} >= ds_r[k]) begin
            dr_r[k+1][l] <= {dr_r[k][l][30:0], dn_r[k][l][30-k]} - ds_r[k];
            dq_r[k+1][l] <= dq_r[k][l] | (31'd1 << (30 - k));
          end else begin
            dr_r[k+1][l] <= {dr_r[k][l][30:0], dn_r[k][l][30-k]};
            dq_r[k+1][l] <= dq_r[k][l];
          end
        end
      end

      for (int l = 0; l < 3; l++) begin
        if (dq_r[DIV_STEPS][l] > (31'd1 << 30)) begin
          u_r[l] <= dg_r[DIV_STEPS][l] ? -Q_ONE : Q_ONE;
        end else begin
          u_r[l] <= dg_r[DIV_STEPS][l] ? -q_t'({3'b000, dq_r[DIV_STEPS][l]})
                                       : q_t'({3'b000, dq_r[DIV_STEPS][l]});
        end
      end
    end
  end

endmodule

FILE: sv/aar_sincos.sv
// Angle unit: reduction to a quadrant and Q30 radians, then a pipelined CORDIC.
module aar_sincos import aar_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] ap,
  input  logic [6:0]  low7,
  output q_t          cos_q,
  output q_t          sin_q
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [17:0] ap0_r, ap1_r;
  logic [6:0]  lo0_r, lo1_r;
  logic [12:0] qa1_r, t2_r, q24_r;
  logic [1:0]  qd2_r, qd3_r, qd4_r;
  logic [31:0] p13_r, p14_r;
  logic [24:0] p23_r;

  q_t         cx_r [CORDIC_STEPS+1];
  q_t         cy_r [CORDIC_STEPS+1];
  q_t         cz_r [CORDIC_STEPS+1];
  logic [1:0] cq_r [CORDIC_STEPS+1];

  q_t c_sel, s_sel, c_r, s_r;

  assign cos_q = c_r;
  assign sin_q = s_r;

  always_comb begin
    case (cq_r[CORDIC_STEPS])
      QUAD_1: begin
        c_sel = -cy_r[CORDIC_STEPS];
        s_sel = cx_r[CORDIC_STEPS];
      end
      QUAD_2: begin
        c_sel = -cx_r[CORDIC_STEPS];
        s_sel = -cy_r[CORDIC_STEPS];
      end
      QUAD_3: begin
        c_sel = cy_r[CORDIC_STEPS];
        s_sel = -cx_r[CORDIC_STEPS];
      end
      QUAD_0: begin
        c_sel = cx_r[CORDIC_STEPS];
        s_sel = cy_r[CORDIC_STEPS];
      end
      default: begin
        c_sel = cx_r[CORDIC_STEPS];
        s_sel = cy_r[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ap0_r <= ap;
      lo0_r <= low7;
      // divide by 45 through a reciprocal, exact over this range
      qa1_r <= 13'((37'(ap0_r) * 37'd372828) >> 24);
      ap1_r <= ap0_r;
      lo1_r <= lo0_r;
      t2_r  <= {6'(ap1_r - 18'(qa1_r) * 18'd45), lo1_r};
      qd2_r <= qa1_r[1:0];
      // theta = t * 292817 + round of the fractional part over 5760
      p13_r <= 32'(t2_r) * 32'd292817;
      p23_r <= 25'(t2_r) * 25'd3793 + 25'd2880;
      qd3_r <= qd2_r;
      q24_r <= 13'((37'(p23_r[24:7]) * 37'd372828) >> 24);
      p14_r <= p13_r;
      qd4_r <= qd3_r;

      cx_r[0] <= CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= q_t'({2'b00, p14_r}) + q_t'({21'd0, q24_r});
      cq_r[0] <= qd4_r;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        cq_r[k+1] <= cq_r[k];
        if (!cz_r[k][33]) begin
          cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] - atan_q30(5'(k));
        end else begin
          cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
          cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
          cz_r[k+1] <= cz_r[k] + atan_q30(5'(k));
        end
      end

      c_r <= clampq(c_sel);
      s_r <= clampq(s_sel);
    end
  end

endmodule

FILE: sv/aar_back.sv
// Back part: axis and angle units, alignment, Rodrigues products and the output register.
module aar_back import aar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  front_item_t      head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [8:0][15:0] rot,
  output logic             zero_axis
);

  logic               en;
  logic [LAT_ALL-1:0] vld_r, zf_r;

  q_t u [3];
  q_t cos_q, sin_q;
  q_t dc_r [LAT_ALIGN];
  q_t dsn_r [LAT_ALIGN];

  q_t sq1_r [3];
  q_t uxy1_r, uyz1_r, uzx1_r, xs1_r, ys1_r, zs1_r, c1_r, omc1_r;
  q_t dg2_r [3];
  q_t pxy2_r, pyz2_r, pzx2_r, xs2_r, ys2_r, zs2_r;
  q_t m3_r [9];
  logic [8:0][15:0] rot_r;

  // the whole back pipeline holds while a finished result waits
  assign en        = !vld_r[LAT_ALL-1] || out_ready;
  assign pop       = en && head_valid;
  assign out_valid = vld_r[LAT_ALL-1];
  assign zero_axis = zf_r[LAT_ALL-1];
  assign rot       = rot_r;

  aar_axis u_axis (
    .clk  (clk),
    .en   (en),
    .mag  (head.mag),
    .neg  (head.neg),
    .len2 (head.len2),
    .u    (u)
  );

  aar_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .ap    (head.ap),
    .low7  (head.low7),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT_ALL-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r <= {zf_r[LAT_ALL-2:0], head.zero};

      dc_r[0]  <= cos_q;
      dsn_r[0] <= sin_q;
      for (int i = 1; i < LAT_ALIGN; i++) begin
        dc_r[i]  <= dc_r[i-1];
        dsn_r[i] <= dsn_r[i-1];
      end

      for (int i = 0; i < 3; i++) sq1_r[i] <= mulq(u[i], u[i]);
      uxy1_r <= mulq(u[0], u[1]);
      uyz1_r <= mulq(u[1], u[2]);
      uzx1_r <= mulq(u[2], u[0]);
      xs1_r  <= mulq(u[0], dsn_r[LAT_ALIGN-1]);
      ys1_r  <= mulq(u[1], dsn_r[LAT_ALIGN-1]);
      zs1_r  <= mulq(u[2], dsn_r[LAT_ALIGN-1]);
      c1_r   <= dc_r[LAT_ALIGN-1];
      omc1_r <= Q_ONE - dc_r[LAT_ALIGN-1];

      for (int i = 0; i < 3; i++) dg2_r[i] <= sq1_r[i] + mulq(c1_r, Q_ONE - sq1_r[i]);
      pxy2_r <= mulq(uxy1_r, omc1_r);
      pyz2_r <= mulq(uyz1_r, omc1_r);
      pzx2_r <= mulq(uzx1_r, omc1_r);
      xs2_r  <= xs1_r;
      ys2_r  <= ys1_r;
      zs2_r  <= zs1_r;

      m3_r[0] <= dg2_r[0];
      m3_r[1] <= pxy2_r - zs2_r;
      m3_r[2] <= pzx2_r + ys2_r;
      m3_r[3] <= pxy2_r + zs2_r;
      m3_r[4] <= dg2_r[1];
      m3_r[5] <= pyz2_r - xs2_r;
      m3_r[6] <= pzx2_r - ys2_r;
      m3_r[7] <= pyz2_r + xs2_r;
      m3_r[8] <= dg2_r[2];

      // zero-length axis: identity
      for (int i = 0; i < 9; i++) begin
        if (zf_r[LAT_ALL-2]) rot_r[i] <= (i % 4 == 0) ? ID_DIAG : 16'd0;
        else rot_r[i] <= to_out(m3_r[i]);
      end
    end
  end

endmodule

FILE: sv/axis_angle_to_rotation_matrix.sv
// Top level of the axis-angle to 3x3 rotation matrix stream block.
// Takes one request per cycle while the queue is not full and gives one matrix
// per request, in order. An accepted request passes the front register, a
// four-entry queue, then a 75-stage back pipeline
// whose length is set by the axis unit (5 normalising steps, a 31-step square
// root and three 31-step divisions, one bit per stage); the CORDIC of
// CORDIC_STEPS stages runs beside it and is delayed to match. While the output
// waits, the back pipeline holds and the queue keeps taking requests until full.
module axis_angle_to_rotation_matrix import aar_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // axis_x, axis_y, axis_z, angle_deg
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // rot_00, rot_01, rot_02, rot_10 .. rot_22
  output logic [0:0]   out_tuser   // zero_axis
);

  logic             q_full, q_not_empty, push, pop, zero_axis;
  front_item_t      f_item, q_head;
  logic [8:0][15:0] rot;

  aar_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .axis_x    (in_tdata[15:0]),
    .axis_y    (in_tdata[31:16]),
    .axis_z    (in_tdata[47:32]),
    .angle_deg (in_tdata[71:48]),
    .q_full    (q_full),
    .push      (push),
    .item      (f_item)
  );

  aar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (f_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  aar_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (q_head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .rot        (rot),
    .zero_axis  (zero_axis)
  );

  assign out_tdata    = rot;
  assign out_tuser[0] = zero_axis;

endmodule
